// ===== hdl/rpac_pkg.sv =====
// ----------------------------------------------------------------------------
// rpac_pkg
// widths, constants, stage map and helpers for the rigid pose unit
// ----------------------------------------------------------------------------
package rpac_pkg;

    // field widths
    localparam int ROT_W  = 32;
    localparam int POS_W  = 48;
    localparam int DIF_W  = 49;
    localparam int SQ_W   = 63;
    localparam int ROOT_W = 64;
    localparam int TH_W   = 32;
    localparam int ANG_W  = 33;
    localparam int RED_W  = 35;
    localparam int SN_W   = 31;
    localparam int NUM_W  = 63;
    localparam int QT_W   = 31;
    localparam int U_W    = 32;
    localparam int TP_LW  = 58;
    localparam int TP_HW  = 56;
    localparam int TACC_W = 82;
    localparam int TM_W   = 52;
    localparam int T_W    = 53;
    localparam int EP_W   = 59;
    localparam int EACC_W = 86;
    localparam int EM_W   = 56;
    localparam int E_W    = 57;
    localparam int H_W    = 58;
    localparam int WIDE_W = 62;

    // iteration counts
    localparam int RT_N = 32;
    localparam int CD_N = 30;
    localparam int DV_N = 31;

    // stage map: index of the register that holds each step's result
    localparam int S_SQ    = 0;
    localparam int S_SUM   = 1;
    localparam int S_RT0   = 2;
    localparam int S_RED   = S_RT0 + RT_N;
    localparam int S_CD0   = S_RED + 1;
    localparam int S_SC    = S_CD0 + CD_N;
    localparam int S_NUM   = S_SC + 1;
    localparam int S_DV0   = S_NUM + 1;
    localparam int S_U     = S_DV0 + DV_N;
    localparam int S_TP    = S_U + 1;
    localparam int S_TM    = S_TP + 1;
    localparam int S_T     = S_TM + 1;
    localparam int S_EP    = S_T + 1;
    localparam int S_EM    = S_EP + 1;
    localparam int S_EH    = S_EM + 1;
    localparam int S_ROT   = S_EH + 1;
    localparam int S_MV    = S_ROT + 1;
    localparam int S_CL    = S_MV + 1;
    localparam int S_OUT   = S_CL + 1;
    localparam int N_STAGE = S_OUT + 1;

    // angle constants, LSB 2^-30 rad
    localparam logic signed [RED_W-1:0] ANG_PI      = 35'sd3373259426;
    localparam logic signed [RED_W-1:0] ANG_NEG_PI  = -35'sd3373259426;
    localparam logic signed [RED_W-1:0] ANG_TWOPI   = 35'sd6746518852;
    localparam logic signed [RED_W-1:0] ANG_HALFPI  = 35'sd1686629713;
    localparam logic signed [RED_W-1:0] ANG_NHALFPI = -35'sd1686629713;
    localparam logic signed [ANG_W-1:0] CORDIC_K    = 33'sd652032874;
    localparam logic signed [U_W-1:0]   ONE_Q30     = 32'sd1073741824;

    localparam logic signed [WIDE_W-1:0] POS_MAX = 62'sd140737488355327;
    localparam logic signed [WIDE_W-1:0] POS_MIN = -62'sd140737488355328;

    // cross product operand order: r[k] = m[2k] - m[2k+1], m = a[CR_A] * b[CR_B]
    localparam int CR_A [6] = '{2, 1, 0, 2, 1, 0};
    localparam int CR_B [6] = '{1, 2, 2, 0, 0, 1};

    typedef struct packed {
        logic [2:0][ROT_W-1:0] rot;
        logic [2:0][DIF_W-1:0] dif;
        logic [2:0][DIF_W-1:0] base;
        logic [2:0][POS_W-1:0] pos;
        logic [TH_W-1:0]       theta;
        logic                  tzero;
        logic                  neg;
        logic [U_W-1:0]        w;
        logic [2:0][U_W-1:0]   u;
    } side_t;

    typedef struct packed {
        logic [POS_W-1:0] val;
        logic             sat;
    } clamp_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 33'sd843314857;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043837;
            3:  v = 33'sd133525159;
            4:  v = 33'sd67021687;
            5:  v = 33'sd33543516;
            6:  v = 33'sd16775851;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194283;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048576;
            11: v = 33'sd524288;
            12: v = 33'sd262144;
            13: v = 33'sd131072;
            14: v = 33'sd65536;
            15: v = 33'sd32768;
            16: v = 33'sd16384;
            17: v = 33'sd8192;
            18: v = 33'sd4096;
            19: v = 33'sd2048;
            20: v = 33'sd1024;
            21: v = 33'sd512;
            22: v = 33'sd256;
            23: v = 33'sd128;
            24: v = 33'sd64;
            25: v = 33'sd32;
            26: v = 33'sd16;
            27: v = 33'sd8;
            28: v = 33'sd4;
            29: v = 33'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic clamp_t clamp48(input logic signed [WIDE_W-1:0] v);
        clamp_t c;
        if (v > POS_MAX) begin
            c.val = POS_MAX[POS_W-1:0];
            c.sat = 1'b1;
        end else if (v < POS_MIN) begin
            c.val = POS_MIN[POS_W-1:0];
            c.sat = 1'b1;
        end else begin
            c.val = v[POS_W-1:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

// ===== hdl/rigid_pose_about_center_unit.sv =====
// ----------------------------------------------------------------------------
// rigid_pose_about_center_unit
// throughput: one transfer per cycle unless a result waits on m_ready; the depth is set
//   by the 32-step root, the 30-step cordic and the 31-step divider standing in series
// reset: aresetn clears the stage valid bits only, no clearing pass
// ----------------------------------------------------------------------------
module rigid_pose_about_center_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rpac_pkg::ROT_W-1:0]   s_rot_x,
    input  logic signed [rpac_pkg::ROT_W-1:0]   s_rot_y,
    input  logic signed [rpac_pkg::ROT_W-1:0]   s_rot_z,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_shift_x,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_shift_y,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_shift_z,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_pos_y,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_pos_z,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_center_x,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_center_y,
    input  logic signed [rpac_pkg::POS_W-1:0]   s_center_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rpac_pkg::POS_W-1:0]   m_moved_x,
    output logic signed [rpac_pkg::POS_W-1:0]   m_moved_y,
    output logic signed [rpac_pkg::POS_W-1:0]   m_moved_z,
    output logic signed [rpac_pkg::POS_W-1:0]   m_offset_x,
    output logic signed [rpac_pkg::POS_W-1:0]   m_offset_y,
    output logic signed [rpac_pkg::POS_W-1:0]   m_offset_z,
    output logic                                m_saturated
);

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together; the whole line holds
    // only while the last stage carries a result that is not taken
    // ------------------------------------------------------------------
    logic [rpac_pkg::N_STAGE-1:0] vld_reg;
    logic                         pipe_en;

    assign pipe_en = !vld_reg[rpac_pkg::N_STAGE-1] || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = vld_reg[rpac_pkg::N_STAGE-1];

    // ------------------------------------------------------------------
    // sideband: operands and per-item values that later stages need
    // ride along in one delay line, fields are filled in as produced
    // ------------------------------------------------------------------
    rpac_pkg::side_t side_reg  [rpac_pkg::N_STAGE];
    rpac_pkg::side_t side_next [rpac_pkg::N_STAGE];

    // input fields gathered per axis
    logic signed [rpac_pkg::ROT_W-1:0] in_rot   [3];
    logic signed [rpac_pkg::POS_W-1:0] in_shift [3];
    logic signed [rpac_pkg::POS_W-1:0] in_pos   [3];
    logic signed [rpac_pkg::POS_W-1:0] in_ctr   [3];

    // squared magnitude of the rotation vector
    logic [rpac_pkg::SQ_W-1:0]   sq_reg  [3];
    logic [rpac_pkg::SQ_W-1:0]   sq_next [3];
    logic [rpac_pkg::ROOT_W-1:0] sum_reg, sum_next;

    // digit-by-digit square root, one step per stage
    logic [rpac_pkg::ROOT_W-1:0] rtn_reg  [rpac_pkg::RT_N];
    logic [rpac_pkg::ROOT_W-1:0] rtn_next [rpac_pkg::RT_N];
    logic [rpac_pkg::ROOT_W-1:0] rtr_reg  [rpac_pkg::RT_N];
    logic [rpac_pkg::ROOT_W-1:0] rtr_next [rpac_pkg::RT_N];
    logic [rpac_pkg::ROOT_W-1:0] rt_in_n  [rpac_pkg::RT_N];
    logic [rpac_pkg::ROOT_W-1:0] rt_in_r  [rpac_pkg::RT_N];

    // cordic, index 0 holds the range-reduced start point
    logic signed [rpac_pkg::ANG_W-1:0] cx_reg  [rpac_pkg::CD_N+1];
    logic signed [rpac_pkg::ANG_W-1:0] cx_next [rpac_pkg::CD_N+1];
    logic signed [rpac_pkg::ANG_W-1:0] cy_reg  [rpac_pkg::CD_N+1];
    logic signed [rpac_pkg::ANG_W-1:0] cy_next [rpac_pkg::CD_N+1];
    logic signed [rpac_pkg::ANG_W-1:0] cz_reg  [rpac_pkg::CD_N+1];
    logic signed [rpac_pkg::ANG_W-1:0] cz_next [rpac_pkg::CD_N+1];

    // sine magnitude and sign
    logic [rpac_pkg::SN_W-1:0] snm_reg, snm_next;
    logic                      snn_reg, snn_next;

    // dividend sin * r_k and quotient sign
    logic [rpac_pkg::NUM_W-1:0] num_reg  [3];
    logic [rpac_pkg::NUM_W-1:0] num_next [3];
    logic                       qng_reg  [3];
    logic                       qng_next [3];

    // restoring divider by theta, one quotient bit per stage, three lanes
    logic [rpac_pkg::NUM_W-1:0] dvr_reg  [rpac_pkg::DV_N][3];
    logic [rpac_pkg::NUM_W-1:0] dvr_next [rpac_pkg::DV_N][3];
    logic [rpac_pkg::QT_W-1:0]  dvq_reg  [rpac_pkg::DV_N][3];
    logic [rpac_pkg::QT_W-1:0]  dvq_next [rpac_pkg::DV_N][3];
    logic                       dvn_reg  [rpac_pkg::DV_N][3];
    logic                       dvn_next [rpac_pkg::DV_N][3];
    logic [rpac_pkg::NUM_W-1:0] dv_in_r  [rpac_pkg::DV_N][3];
    logic [rpac_pkg::QT_W-1:0]  dv_in_q  [rpac_pkg::DV_N][3];
    logic                       dv_in_n  [rpac_pkg::DV_N][3];

    // t = u x d: partial products, rounded products, difference
    logic signed [rpac_pkg::TP_LW-1:0] tpl_reg  [6];
    logic signed [rpac_pkg::TP_LW-1:0] tpl_next [6];
    logic signed [rpac_pkg::TP_HW-1:0] tph_reg  [6];
    logic signed [rpac_pkg::TP_HW-1:0] tph_next [6];
    logic signed [rpac_pkg::TM_W-1:0]  tm_reg   [6];
    logic signed [rpac_pkg::TM_W-1:0]  tm_next  [6];
    logic signed [rpac_pkg::T_W-1:0]   t_reg    [3];
    logic signed [rpac_pkg::T_W-1:0]   t_next   [3];

    // e = u x t and w * t share one product bank of nine
    logic signed [rpac_pkg::EP_W-1:0] epl_reg  [9];
    logic signed [rpac_pkg::EP_W-1:0] epl_next [9];
    logic signed [rpac_pkg::EP_W-1:0] eph_reg  [9];
    logic signed [rpac_pkg::EP_W-1:0] eph_next [9];
    logic signed [rpac_pkg::EM_W-1:0] em_reg   [9];
    logic signed [rpac_pkg::EM_W-1:0] em_next  [9];
    logic signed [rpac_pkg::E_W-1:0]  e_reg    [3];
    logic signed [rpac_pkg::E_W-1:0]  e_next   [3];
    logic signed [rpac_pkg::H_W-1:0]  h_reg    [3];
    logic signed [rpac_pkg::H_W-1:0]  h_next   [3];

    // rotated offset, moved point, clamp
    logic signed [rpac_pkg::WIDE_W-1:0] rot_reg  [3];
    logic signed [rpac_pkg::WIDE_W-1:0] rot_next [3];
    logic signed [rpac_pkg::WIDE_W-1:0] mv_reg   [3];
    logic signed [rpac_pkg::WIDE_W-1:0] mv_next  [3];
    logic signed [rpac_pkg::WIDE_W-1:0] ow_reg   [3];
    logic signed [rpac_pkg::WIDE_W-1:0] ow_next  [3];
    logic [rpac_pkg::POS_W-1:0]         mc_reg   [3];
    logic [rpac_pkg::POS_W-1:0]         mc_next  [3];
    logic                               msat_reg, msat_next;

    // output register
    logic [rpac_pkg::POS_W-1:0] mo_reg  [3];
    logic [rpac_pkg::POS_W-1:0] mo_next [3];
    logic [rpac_pkg::POS_W-1:0] of_reg  [3];
    logic [rpac_pkg::POS_W-1:0] of_next [3];
    logic                       sat_reg, sat_next;

    always_comb begin
        in_rot[0]   = s_rot_x;
        in_rot[1]   = s_rot_y;
        in_rot[2]   = s_rot_z;
        in_shift[0] = s_shift_x;
        in_shift[1] = s_shift_y;
        in_shift[2] = s_shift_z;
        in_pos[0]   = s_pos_x;
        in_pos[1]   = s_pos_y;
        in_pos[2]   = s_pos_z;
        in_ctr[0]   = s_center_x;
        in_ctr[1]   = s_center_y;
        in_ctr[2]   = s_center_z;
    end

    // ------------------------------------------------------------------
    // front: squares, offset from center, center plus shift
    // ------------------------------------------------------------------
    always_comb begin
        logic [rpac_pkg::ROT_W-1:0] rmag;
        for (int k = 0; k < 3; k++) begin
            rmag = in_rot[k][rpac_pkg::ROT_W-1] ? (~in_rot[k] + 1'b1) : in_rot[k];
            sq_next[k] = rpac_pkg::SQ_W'({32'b0, rmag} * {32'b0, rmag});
        end
        sum_next = rpac_pkg::ROOT_W'(sq_reg[0]) + rpac_pkg::ROOT_W'(sq_reg[1])
                 + rpac_pkg::ROOT_W'(sq_reg[2]);
    end

    // ------------------------------------------------------------------
    // square root: test res + bit against the remainder each stage
    // ------------------------------------------------------------------
    always_comb begin
        logic [rpac_pkg::ROOT_W-1:0] bitv;
        logic [rpac_pkg::ROOT_W-1:0] trial;
        rt_in_n[0] = sum_reg;
        rt_in_r[0] = '0;
        for (int i = 1; i < rpac_pkg::RT_N; i++) begin
            rt_in_n[i] = rtn_reg[i-1];
            rt_in_r[i] = rtr_reg[i-1];
        end
        for (int i = 0; i < rpac_pkg::RT_N; i++) begin
            bitv  = rpac_pkg::ROOT_W'(1) << (62 - 2 * i);
            trial = rt_in_r[i] + bitv;
            if (rt_in_n[i] >= trial) begin
                rtn_next[i] = rt_in_n[i] - trial;
                rtr_next[i] = (rt_in_r[i] >> 1) + bitv;
            end else begin
                rtn_next[i] = rt_in_n[i];
                rtr_next[i] = rt_in_r[i] >> 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // half angle reduction and cordic rotation
    // ------------------------------------------------------------------
    logic [rpac_pkg::TH_W-1:0] red_theta;
    logic                      red_neg;

    always_comb begin
        logic signed [rpac_pkg::RED_W-1:0] z;
        logic signed [rpac_pkg::ANG_W-1:0] xs;
        logic signed [rpac_pkg::ANG_W-1:0] ys;
        red_theta = rtr_reg[rpac_pkg::RT_N-1][rpac_pkg::TH_W-1:0];
        z = $signed({2'b00, red_theta, 1'b0});
        red_neg = 1'b0;
        if (z > rpac_pkg::ANG_PI) begin
            z = z - rpac_pkg::ANG_TWOPI;
        end
        if (z > rpac_pkg::ANG_HALFPI) begin
            z = rpac_pkg::ANG_PI - z;
            red_neg = 1'b1;
        end else if (z < rpac_pkg::ANG_NHALFPI) begin
            z = rpac_pkg::ANG_NEG_PI - z;
            red_neg = 1'b1;
        end
        cx_next[0] = rpac_pkg::CORDIC_K;
        cy_next[0] = '0;
        cz_next[0] = z[rpac_pkg::ANG_W-1:0];
        for (int i = 0; i < rpac_pkg::CD_N; i++) begin
            xs = cx_reg[i] >>> i;
            ys = cy_reg[i] >>> i;
            if (!cz_reg[i][rpac_pkg::ANG_W-1]) begin
                cx_next[i+1] = cx_reg[i] - ys;
                cy_next[i+1] = cy_reg[i] + xs;
                cz_next[i+1] = cz_reg[i] - rpac_pkg::atan_q30(i);
            end else begin
                cx_next[i+1] = cx_reg[i] + ys;
                cy_next[i+1] = cy_reg[i] - xs;
                cz_next[i+1] = cz_reg[i] + rpac_pkg::atan_q30(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // cosine / sine pick-up, zero rotation gives identity
    // ------------------------------------------------------------------
    logic signed [rpac_pkg::ANG_W-1:0] sc_w;

    always_comb begin
        logic signed [rpac_pkg::ANG_W-1:0] xf;
        logic signed [rpac_pkg::ANG_W-1:0] yf;
        logic signed [rpac_pkg::ANG_W-1:0] ya;
        xf = cx_reg[rpac_pkg::CD_N];
        yf = cy_reg[rpac_pkg::CD_N];
        ya = yf[rpac_pkg::ANG_W-1] ? -yf : yf;
        if (side_reg[rpac_pkg::S_SC-1].tzero) begin
            sc_w     = rpac_pkg::ANG_W'(rpac_pkg::ONE_Q30);
            snm_next = '0;
            snn_next = 1'b0;
        end else begin
            sc_w     = side_reg[rpac_pkg::S_SC-1].neg ? -xf : xf;
            snm_next = ya[rpac_pkg::SN_W-1:0];
            snn_next = yf[rpac_pkg::ANG_W-1];
        end
    end

    // ------------------------------------------------------------------
    // dividend |sin| * |r_k| and the divider lanes
    // ------------------------------------------------------------------
    always_comb begin
        logic [rpac_pkg::ROT_W-1:0]  rmag;
        logic [rpac_pkg::ROOT_W-1:0] dsh;
        logic [rpac_pkg::ROOT_W-1:0] rem;
        for (int k = 0; k < 3; k++) begin
            rmag = side_reg[rpac_pkg::S_NUM-1].rot[k][rpac_pkg::ROT_W-1]
                 ? (~side_reg[rpac_pkg::S_NUM-1].rot[k] + 1'b1)
                 : side_reg[rpac_pkg::S_NUM-1].rot[k];
            num_next[k] = rpac_pkg::NUM_W'({33'b0, snm_reg} * {32'b0, rmag});
            qng_next[k] = snn_reg ^ side_reg[rpac_pkg::S_NUM-1].rot[k][rpac_pkg::ROT_W-1];
        end
        for (int k = 0; k < 3; k++) begin
            dv_in_r[0][k] = num_reg[k];
            dv_in_q[0][k] = '0;
            dv_in_n[0][k] = qng_reg[k];
        end
        for (int j = 1; j < rpac_pkg::DV_N; j++) begin
            for (int k = 0; k < 3; k++) begin
                dv_in_r[j][k] = dvr_reg[j-1][k];
                dv_in_q[j][k] = dvq_reg[j-1][k];
                dv_in_n[j][k] = dvn_reg[j-1][k];
            end
        end
        for (int j = 0; j < rpac_pkg::DV_N; j++) begin
            dsh = rpac_pkg::ROOT_W'(side_reg[rpac_pkg::S_DV0+j-1].theta)
                  << (rpac_pkg::QT_W - 1 - j);
            for (int k = 0; k < 3; k++) begin
                rem = {1'b0, dv_in_r[j][k]};
                dvq_next[j][k] = dv_in_q[j][k];
                dvn_next[j][k] = dv_in_n[j][k];
                if (rem >= dsh) begin
                    dvr_next[j][k] = dv_in_r[j][k] - dsh[rpac_pkg::NUM_W-1:0];
                    dvq_next[j][k][rpac_pkg::QT_W-1-j] = 1'b1;
                end else begin
                    dvr_next[j][k] = dv_in_r[j][k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // quaternion vector part, signed and truncated toward zero
    // ------------------------------------------------------------------
    logic signed [rpac_pkg::U_W-1:0] u_val [3];

    always_comb begin
        logic signed [rpac_pkg::U_W-1:0] qm;
        for (int k = 0; k < 3; k++) begin
            qm = $signed({1'b0, dvq_reg[rpac_pkg::DV_N-1][k]});
            if (side_reg[rpac_pkg::S_U-1].tzero) begin
                u_val[k] = '0;
            end else begin
                u_val[k] = dvn_reg[rpac_pkg::DV_N-1][k] ? -qm : qm;
            end
        end
    end

    // ------------------------------------------------------------------
    // t = u x d, each wide product split in two halves
    // ------------------------------------------------------------------
    always_comb begin
        logic [rpac_pkg::DIF_W-1:0]         av;
        logic signed [rpac_pkg::U_W-1:0]    bv;
        logic signed [rpac_pkg::TACC_W-1:0] acc;
        for (int m = 0; m < 6; m++) begin
            av = side_reg[rpac_pkg::S_TP-1].dif[rpac_pkg::CR_A[m]];
            bv = $signed(side_reg[rpac_pkg::S_TP-1].u[rpac_pkg::CR_B[m]]);
            tpl_next[m] = rpac_pkg::TP_LW'($signed({1'b0, av[24:0]}))
                        * rpac_pkg::TP_LW'(bv);
            tph_next[m] = rpac_pkg::TP_HW'($signed(av[rpac_pkg::DIF_W-1:25]))
                        * rpac_pkg::TP_HW'(bv);
        end
        for (int m = 0; m < 6; m++) begin
            acc = (rpac_pkg::TACC_W'(tph_reg[m]) <<< 25) + rpac_pkg::TACC_W'(tpl_reg[m])
                + (rpac_pkg::TACC_W'(1) <<< 29);
            tm_next[m] = acc[rpac_pkg::TACC_W-1:30];
        end
        for (int k = 0; k < 3; k++) begin
            t_next[k] = rpac_pkg::T_W'(tm_reg[2*k]) - rpac_pkg::T_W'(tm_reg[2*k+1]);
        end
    end

    // ------------------------------------------------------------------
    // e = u x t and w * t, then R(d) = d + 2 w t + 2 e
    // ------------------------------------------------------------------
    always_comb begin
        logic [rpac_pkg::T_W-1:0]           av;
        logic signed [rpac_pkg::U_W-1:0]    bv;
        logic signed [rpac_pkg::EACC_W-1:0] acc;
        for (int m = 0; m < 9; m++) begin
            if (m < 6) begin
                av = t_reg[rpac_pkg::CR_A[m]];
                bv = $signed(side_reg[rpac_pkg::S_EP-1].u[rpac_pkg::CR_B[m]]);
            end else begin
                av = t_reg[m-6];
                bv = $signed(side_reg[rpac_pkg::S_EP-1].w);
            end
            epl_next[m] = rpac_pkg::EP_W'($signed({1'b0, av[25:0]}))
                        * rpac_pkg::EP_W'(bv);
            eph_next[m] = rpac_pkg::EP_W'($signed(av[rpac_pkg::T_W-1:26]))
                        * rpac_pkg::EP_W'(bv);
        end
        for (int m = 0; m < 9; m++) begin
            acc = (rpac_pkg::EACC_W'(eph_reg[m]) <<< 26) + rpac_pkg::EACC_W'(epl_reg[m])
                + (rpac_pkg::EACC_W'(1) <<< 29);
            em_next[m] = acc[rpac_pkg::EACC_W-1:30];
        end
        for (int k = 0; k < 3; k++) begin
            e_next[k] = rpac_pkg::E_W'(em_reg[2*k]) - rpac_pkg::E_W'(em_reg[2*k+1]);
            h_next[k] = rpac_pkg::H_W'($signed(side_reg[rpac_pkg::S_EH-1].dif[k]))
                      + (rpac_pkg::H_W'(em_reg[6+k]) <<< 1);
            rot_next[k] = rpac_pkg::WIDE_W'(h_reg[k]) + (rpac_pkg::WIDE_W'(e_reg[k]) <<< 1);
            mv_next[k]  = rot_reg[k]
                        + rpac_pkg::WIDE_W'($signed(side_reg[rpac_pkg::S_MV-1].base[k]));
        end
    end

    // ------------------------------------------------------------------
    // offset from the original point and saturation at the outputs
    // ------------------------------------------------------------------
    always_comb begin
        rpac_pkg::clamp_t cm;
        rpac_pkg::clamp_t co;
        msat_next = 1'b0;
        sat_next  = msat_reg;
        for (int k = 0; k < 3; k++) begin
            cm = rpac_pkg::clamp48(mv_reg[k]);
            mc_next[k] = cm.val;
            msat_next  = msat_next | cm.sat;
            ow_next[k] = mv_reg[k]
                       - rpac_pkg::WIDE_W'($signed(side_reg[rpac_pkg::S_CL-1].pos[k]));
            co = rpac_pkg::clamp48(ow_reg[k]);
            mo_next[k] = mc_reg[k];
            of_next[k] = co.val;
            sat_next   = sat_next | co.sat;
        end
    end

    // ------------------------------------------------------------------
    // sideband line with the fields filled in where they appear
    // ------------------------------------------------------------------
    always_comb begin
        side_next[0] = '0;
        for (int k = 0; k < 3; k++) begin
            side_next[0].rot[k]  = in_rot[k];
            side_next[0].dif[k]  = rpac_pkg::DIF_W'(in_pos[k]) - rpac_pkg::DIF_W'(in_ctr[k]);
            side_next[0].base[k] = rpac_pkg::DIF_W'(in_ctr[k]) + rpac_pkg::DIF_W'(in_shift[k]);
            side_next[0].pos[k]  = in_pos[k];
        end
        for (int s = 1; s < rpac_pkg::N_STAGE; s++) begin
            side_next[s] = side_reg[s-1];
        end
        side_next[rpac_pkg::S_RED].theta = red_theta;
        side_next[rpac_pkg::S_RED].tzero = (red_theta == '0);
        side_next[rpac_pkg::S_RED].neg   = red_neg;
        side_next[rpac_pkg::S_SC].w      = sc_w[rpac_pkg::U_W-1:0];
        for (int k = 0; k < 3; k++) begin
            side_next[rpac_pkg::S_U].u[k] = u_val[k];
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[rpac_pkg::N_STAGE-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_reg <= side_next;
            sq_reg   <= sq_next;
            sum_reg  <= sum_next;
            rtn_reg  <= rtn_next;
            rtr_reg  <= rtr_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            cz_reg   <= cz_next;
            snm_reg  <= snm_next;
            snn_reg  <= snn_next;
            num_reg  <= num_next;
            qng_reg  <= qng_next;
            dvr_reg  <= dvr_next;
            dvq_reg  <= dvq_next;
            dvn_reg  <= dvn_next;
            tpl_reg  <= tpl_next;
            tph_reg  <= tph_next;
            tm_reg   <= tm_next;
            t_reg    <= t_next;
            epl_reg  <= epl_next;
            eph_reg  <= eph_next;
            em_reg   <= em_next;
            e_reg    <= e_next;
            h_reg    <= h_next;
            rot_reg  <= rot_next;
            mv_reg   <= mv_next;
            ow_reg   <= ow_next;
            mc_reg   <= mc_next;
            msat_reg <= msat_next;
            mo_reg   <= mo_next;
            of_reg   <= of_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_moved_x   = mo_reg[0];
    assign m_moved_y   = mo_reg[1];
    assign m_moved_z   = mo_reg[2];
    assign m_offset_x  = of_reg[0];
    assign m_offset_y  = of_reg[1];
    assign m_offset_z  = of_reg[2];
    assign m_saturated = sat_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives random and directed poses into rigid_pose_about_center_unit and
// compares every result against a bit-true fixed-point predictor
// ----------------------------------------------------------------------------
module testbench;

    localparam int PW = rpac_pkg::POS_W;
    localparam int RW = rpac_pkg::ROT_W;
    localparam int N_RANDOM = 750;

    // one pose application as it crosses the input port
    typedef struct packed {
        logic [2:0][RW-1:0] rot;
        logic [2:0][PW-1:0] shift;
        logic [2:0][PW-1:0] pos;
        logic [2:0][PW-1:0] center;
    } pose_t;

    // one moved point as it leaves the result port
    typedef struct packed {
        logic [2:0][PW-1:0] moved;
        logic [2:0][PW-1:0] offset;
        logic               sat;
    } moved_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts the moved point of each accepted pose and checks
    // results in order
    // ------------------------------------------------------------------------
    class pose_scoreboard;
        moved_t pending_q[$];
        int     errors = 0;

        // round(a * b / 2^30), floor after adding half
        static function longint mul_q30(longint a, longint b);
            logic signed [127:0] aa, bb, pr;
            aa = a;
            bb = b;
            pr = aa * bb + (128'sd1 <<< 29);
            pr = pr >>> 30;
            return longint'(pr);
        endfunction

        static function void cross3(input longint a[3], input longint b[3],
                                    output longint o[3]);
            o[0] = mul_q30(b[2], a[1]) - mul_q30(b[1], a[2]);
            o[1] = mul_q30(b[0], a[2]) - mul_q30(b[2], a[0]);
            o[2] = mul_q30(b[1], a[0]) - mul_q30(b[0], a[1]);
        endfunction

        static function logic [PW-1:0] saturate48(longint v, inout logic flag);
            longint hi, lo;
            hi = longint'(rpac_pkg::POS_MAX);
            lo = longint'(rpac_pkg::POS_MIN);
            if (v > hi) begin
                v = hi;
                flag = 1'b1;
            end
            if (v < lo) begin
                v = lo;
                flag = 1'b1;
            end
            return v[PW-1:0];
        endfunction

        static function moved_t transform(pose_t p);
            longint atan_tab [30] = '{
                843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                128, 64, 32, 16, 8, 4, 2};
            longint r[3], sh[3], ps[3], cn[3], u[3], d[3], t[3], e[3];
            longint w, x, y, z, xs, ys, rot, m;
            logic [63:0] sum, mag, rem, res, bitv, theta;
            logic flag, fold;
            moved_t o;
            sum = 0;
            flag = 1'b0;
            for (int k = 0; k < 3; k++) begin
                r[k]  = longint'($signed(p.rot[k]));
                sh[k] = longint'($signed(p.shift[k]));
                ps[k] = longint'($signed(p.pos[k]));
                cn[k] = longint'($signed(p.center[k]));
                mag = (r[k] < 0) ? -r[k] : r[k];
                sum += mag * mag;
            end
            // digit-by-digit square root
            rem = sum;
            res = 0;
            bitv = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            theta = res;
            if (theta == 0) begin
                w = longint'(rpac_pkg::ONE_Q30);
                u = '{0, 0, 0};
            end else begin
                z = longint'(theta) * 2;
                fold = 1'b0;
                if (z > longint'(rpac_pkg::ANG_PI))
                    z -= longint'(rpac_pkg::ANG_TWOPI);
                if (z > longint'(rpac_pkg::ANG_HALFPI)) begin
                    z = longint'(rpac_pkg::ANG_PI) - z;
                    fold = 1'b1;
                end else if (z < -longint'(rpac_pkg::ANG_HALFPI)) begin
                    z = -longint'(rpac_pkg::ANG_PI) - z;
                    fold = 1'b1;
                end
                x = longint'(rpac_pkg::CORDIC_K);
                y = 0;
                for (int i = 0; i < 30; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (z >= 0) begin
                        x -= ys;
                        y += xs;
                        z -= atan_tab[i];
                    end else begin
                        x += ys;
                        y -= xs;
                        z += atan_tab[i];
                    end
                end
                w = fold ? -x : x;
                for (int k = 0; k < 3; k++)
                    u[k] = (y * r[k]) / longint'(theta);
            end
            for (int k = 0; k < 3; k++)
                d[k] = ps[k] - cn[k];
            cross3(u, d, t);
            cross3(u, t, e);
            for (int k = 0; k < 3; k++) begin
                rot = d[k] + 2 * mul_q30(t[k], w) + 2 * e[k];
                m = cn[k] + rot + sh[k];
                o.moved[k]  = saturate48(m, flag);
                o.offset[k] = saturate48(m - ps[k], flag);
            end
            o.sat = flag;
            return o;
        endfunction

        function void note_pose(pose_t p);
            pending_q.push_back(transform(p));
        endfunction

        function void check_result(moved_t got);
            string  axis [3] = '{"x", "y", "z"};
            moved_t want;
            if (pending_q.size() == 0) begin
                errors++;
                $error("result transfer with no pose outstanding");
                return;
            end
            want = pending_q.pop_front();
            for (int k = 0; k < 3; k++) begin
                if (got.moved[k] !== want.moved[k]) begin
                    errors++;
                    $error("moved_%s expected %0d actual %0d", axis[k],
                           $signed(want.moved[k]), $signed(got.moved[k]));
                end
                if (got.offset[k] !== want.offset[k]) begin
                    errors++;
                    $error("offset_%s expected %0d actual %0d", axis[k],
                           $signed(want.offset[k]), $signed(got.offset[k]));
                end
            end
            if (got.sat !== want.sat) begin
                errors++;
                $error("saturated expected %0b actual %0b", want.sat, got.sat);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, the ones the bench drives known from time zero
    // ------------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [RW-1:0] s_rot_x = '0, s_rot_y = '0, s_rot_z = '0;
    logic signed [PW-1:0] s_shift_x = '0, s_shift_y = '0, s_shift_z = '0;
    logic signed [PW-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [PW-1:0] s_center_x = '0, s_center_y = '0, s_center_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [PW-1:0] m_moved_x, m_moved_y, m_moved_z;
    logic signed [PW-1:0] m_offset_x, m_offset_y, m_offset_z;
    logic m_saturated;

    pose_scoreboard board = new();

    always #10 aclk = ~aclk;

    rigid_pose_about_center_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_rot_x(s_rot_x), .s_rot_y(s_rot_y), .s_rot_z(s_rot_z),
        .s_shift_x(s_shift_x), .s_shift_y(s_shift_y), .s_shift_z(s_shift_z),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_center_x(s_center_x), .s_center_y(s_center_y), .s_center_z(s_center_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_moved_x(m_moved_x), .m_moved_y(m_moved_y), .m_moved_z(m_moved_z),
        .m_offset_x(m_offset_x), .m_offset_y(m_offset_y), .m_offset_z(m_offset_z),
        .m_saturated(m_saturated)
    );

    // ------------------------------------------------------------------------
    // result side: check each transfer, stall in changing modes
    // ------------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            // values read here are the ones from before this edge
            if (m_valid && m_ready)
                board.check_result({m_moved_z, m_moved_y, m_moved_x,
                                    m_offset_z, m_offset_y, m_offset_x,
                                    m_saturated});
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 120);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;                            // never stall
                1: m_ready <= ($urandom_range(0, 1) == 0);     // half the time
                2: m_ready <= ($urandom_range(0, 3) == 0);     // mostly stalled
                default: m_ready <= ((stall_left % 8) < 5);    // periodic
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // present one pose at the current edge and hold it until transferred
    task automatic send_pose(pose_t p);
        s_valid    <= 1'b1;
        s_rot_x    <= p.rot[0];
        s_rot_y    <= p.rot[1];
        s_rot_z    <= p.rot[2];
        s_shift_x  <= p.shift[0];
        s_shift_y  <= p.shift[1];
        s_shift_z  <= p.shift[2];
        s_pos_x    <= p.pos[0];
        s_pos_y    <= p.pos[1];
        s_pos_z    <= p.pos[2];
        s_center_x <= p.center[0];
        s_center_y <= p.center[1];
        s_center_z <= p.center[2];
        do @(posedge aclk); while (!s_ready);
        board.note_pose(p);
    endtask

    // hold off input until the pipeline has drained
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [PW-1:0] rand48();
        return PW'({$urandom(), $urandom()});
    endfunction

    // mostly moderate coordinates so the rotation shows, sometimes full range
    function automatic logic [PW-1:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: return rand48();
            1: begin
                v = $urandom();
                return PW'(v);
            end
            default: begin
                v = $urandom_range(0, 32'h00ff_ffff);
                v = v - 32'sh0080_0000;
                return PW'(v);
            end
        endcase
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        int unsigned kind;
        logic signed [31:0] v;
        kind = $urandom_range(0, 5);
        for (int k = 0; k < 3; k++) begin
            case (kind)
                0, 1: p.rot[k] = $urandom();                         // any angle
                2, 3: begin                                          // up to ~1 rad
                    v = $urandom_range(0, 32'h1fff_ffff);
                    p.rot[k] = v - 32'sh1000_0000;
                end
                4: p.rot[k] = '0;                                    // identity
                default: p.rot[k] = (k == $urandom_range(0, 2)) ? $urandom() : '0;
            endcase
            p.shift[k]  = rand_coord();
            p.pos[k]    = rand_coord();
            p.center[k] = rand_coord();
        end
        return p;
    endfunction

    function automatic pose_t make_pose(logic signed [RW-1:0] rx, logic signed [RW-1:0] ry,
                                        logic signed [RW-1:0] rz, logic [PW-1:0] sh,
                                        logic [PW-1:0] ps, logic [PW-1:0] cn);
        pose_t p;
        p.rot = {rz, ry, rx};
        for (int k = 0; k < 3; k++) begin
            p.shift[k]  = sh;
            p.pos[k]    = ps + PW'(k * 65536);
            p.center[k] = cn - PW'(k * 4096);
        end
        return p;
    endfunction

    localparam logic [PW-1:0] P_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic [PW-1:0] P_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic [PW-1:0] P_ONE = PW'(65536);
    localparam logic signed [RW-1:0] R_MAX = 32'sh7fff_ffff;
    localparam logic signed [RW-1:0] R_MIN = -32'sh8000_0000;
    // rotation magnitudes whose doubled value lands on the half-pi and pi edges
    localparam logic signed [RW-1:0] R_QUARTER = 32'sd843314856;
    localparam logic signed [RW-1:0] R_HALF    = 32'sd1686629713;

    initial begin
        pose_t directed [$];
        int    burst;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed set: identity, extremes, fold and wrap edges, clamping
        directed.push_back(make_pose(0, 0, 0, '0, '0, '0));
        directed.push_back(make_pose(0, 0, 0, P_ONE, P_MAX, '0));
        directed.push_back(make_pose(0, 0, 0, P_MIN, P_MIN, P_MAX));
        directed.push_back(make_pose(0, 0, 0, P_MAX, P_MAX, P_MIN));
        directed.push_back(make_pose(R_MAX, R_MAX, R_MAX, '0, P_ONE, '0));
        directed.push_back(make_pose(R_MIN, R_MIN, R_MIN, '0, P_ONE, '0));
        directed.push_back(make_pose(R_MAX, R_MIN, R_MAX, P_MAX, P_MAX, P_MIN));
        directed.push_back(make_pose(R_MIN, R_MAX, 0, P_MIN, P_MIN, P_MAX));
        directed.push_back(make_pose(1, 0, 0, '0, P_ONE, '0));
        directed.push_back(make_pose(0, -1, 0, '0, P_ONE, P_MIN));
        directed.push_back(make_pose(R_QUARTER, 0, 0, '0, P_ONE, '0));
        directed.push_back(make_pose(R_QUARTER + 2, 0, 0, '0, P_ONE, '0));
        directed.push_back(make_pose(0, R_HALF, 0, '0, P_ONE, '0));
        directed.push_back(make_pose(0, R_HALF + 1, 0, P_ONE, P_ONE, P_ONE));
        directed.push_back(make_pose(0, 0, -R_HALF - 1, '0, P_MAX, P_MIN));
        directed.push_back(make_pose(0, 0, R_MAX, P_MAX, P_MAX, '0));
        directed.push_back(make_pose(32'sh1000_0000, 0, 0, '0, P_ONE, '0));
        directed.push_back(make_pose(-32'sh1000_0000, 32'sh0800_0000, 32'sh0400_0000,
                                     P_MIN, '0, P_MAX));
        directed.push_back(make_pose(32'sh0000_ffff, 32'sh7fff_0000, R_MIN,
                                     '1, '1, '0));
        directed.push_back(make_pose(R_MAX, 0, 0, '1, P_MIN, P_MAX));

        foreach (directed[i])
            send_pose(directed[i]);

        // pipeline empty before the random part starts
        drain_results();

        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2)
                drain_results();
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge aclk);
                end
            end
            send_pose(random_pose());
            burst--;
        end
        s_valid <= 1'b0;

        // wait for the last results, bounded, then let stray ones show up
        for (int c = 0; c < 20000 && board.pending_q.size() != 0; c++)
            @(posedge aclk);
        repeat (150) @(posedge aclk);

        if (board.pending_q.size() != 0) begin
            board.errors++;
            $error("%0d expected results never arrived", board.pending_q.size());
        end

        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
